// ===== rtl/core/src_pkg.sv =====
`default_nettype none

package src_pkg;

  localparam int ANGLE_FRAC_BITS = 12;

  localparam int HEADING_W = 15;
  localparam int DELTA_W = HEADING_W + 3;
  localparam int UNW_W = 24;
  localparam int DIST_W = UNW_W + 1;
  localparam int REM_W = DIST_W + 1;

  localparam int DEG_W = 8;
  localparam int ACCEL_W = 16;
  localparam int RATE_CFG_W = 14;
  localparam int TOL_W = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int RATE_W = 15;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int SHIFT30 = 30 - ANGLE_FRAC_BITS;
  localparam longint unsigned SWING_DEN = 64'd180 << SHIFT30;
  localparam longint unsigned SWING_MAX =
    (64'd255 * PI_Q30 + SWING_DEN / 2) / SWING_DEN;
  localparam int SWING_W = $clog2(SWING_MAX + 1);
  localparam int AMP_W = SWING_W + 1;

  localparam int PROD_W = ACCEL_W + AMP_W + 1;
  localparam int ROOT_W = (PROD_W + 1) / 2;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int PART_W = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);

  localparam logic signed [DELTA_W-1:0] PI_Q =
    DELTA_W'((PI_Q30 + (64'd1 << (SHIFT30 - 1))) >> SHIFT30);
  localparam logic signed [DELTA_W-1:0] HALF_PI_Q =
    DELTA_W'((PI_Q30 + (64'd1 << SHIFT30)) >> (SHIFT30 + 1));

  localparam logic [CFG_IDX_W-1:0] CFG_SWING = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_TOL = CFG_IDX_W'(4);

  localparam logic [DEG_W-1:0] SWING_RST = DEG_W'(20);
  localparam logic [ACCEL_W-1:0] ACCEL_RST = ACCEL_W'(13107);
  localparam logic [RATE_CFG_W-1:0] MAX_RATE_RST = RATE_CFG_W'(4096);
  localparam logic [RATE_CFG_W-1:0] MIN_RATE_RST = RATE_CFG_W'(1638);
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(410);

  typedef enum logic [1:0] {
    PH_POS  = 2'd0,
    PH_NEG  = 2'd1,
    PH_RET  = 2'd2,
    PH_IDLE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ABORT = 2'd2
  } status_t;

  typedef logic [SWING_W-1:0] swing_tbl_t [2**DEG_W];

  // Swing amplitude in radians for every whole-degree setting, rounded to nearest.
  function automatic swing_tbl_t build_swing_tbl();
    swing_tbl_t t;
    longint unsigned num;
    for (int i = 0; i < 2**DEG_W; i++) begin
      num = longint'(i) * PI_Q30;
      t[i] = SWING_W'((num + SWING_DEN / 2) / SWING_DEN);
    end
    return t;
  endfunction

  localparam swing_tbl_t SWING_TBL = build_swing_tbl();

  typedef struct packed {
    logic load;
    logic upd;
    logic meas;
    logic cmp;
    logic mul;
    logic step;
    logic clamp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic upd_stop;
    logic cmp_stop;
    logic sqrt_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/src_ctrl.sv =====
`default_nettype none

module src_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output src_pkg::cmd_t  cmd,
  input  src_pkg::stat_t stat
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPD   = 8'b0000_0010,
    S_DIST  = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_CLAMP = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = stat.upd_stop ? S_OUT : S_DIST;
      end
      S_DIST: begin
        cmd.meas = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        state_next = stat.cmp_stop ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.step = 1'b1;
        if (stat.sqrt_last) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/src_sqrt.sv =====
`default_nettype none

module src_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [src_pkg::RAD_W-1:0]   radicand,
  input  logic                        step,
  output logic [src_pkg::ROOT_W-1:0]  root,
  output logic                        last
);

  logic [src_pkg::RAD_W-1:0]  rad_sh;
  logic [src_pkg::PART_W-1:0] part;
  logic [src_pkg::STEP_W-1:0] count;
  logic [src_pkg::PART_W-1:0] part_sh;
  logic [src_pkg::PART_W-1:0] trial;

  assign part_sh = {part[src_pkg::PART_W-3:0], rad_sh[src_pkg::RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign last = (count == src_pkg::STEP_W'(src_pkg::ROOT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= '0;
    end else if (step) begin
      count <= count + src_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rad_sh <= radicand;
      part <= '0;
      root <= '0;
    end else if (step) begin
      rad_sh <= {rad_sh[src_pkg::RAD_W-3:0], 2'b00};
      if (part_sh >= trial) begin
        part <= part_sh - trial;
        root <= {root[src_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        part <= part_sh;
        root <= {root[src_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/src_dp.sv =====
`default_nettype none

module src_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [src_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [src_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 start_run,
  input  logic signed [src_pkg::HEADING_W-1:0] heading,
  input  logic                                 cancel_req,
  input  logic                                 collision_ahead,
  input  src_pkg::cmd_t                        cmd,
  output src_pkg::stat_t                       stat,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [src_pkg::RATE_W-1:0]    turn_rate,
  output logic [1:0]                           phase_now,
  output logic [1:0]                           run_status
);

  localparam int HW = src_pkg::HEADING_W;
  localparam int DW = src_pkg::DELTA_W;
  localparam int UW = src_pkg::UNW_W;
  localparam int RW = src_pkg::REM_W;
  localparam int AW = src_pkg::AMP_W;
  localparam int QW = src_pkg::ROOT_W;
  localparam int CW = src_pkg::RATE_CFG_W;
  localparam int OW = src_pkg::RATE_W;

  logic [src_pkg::DEG_W-1:0]   swing_angle_deg;
  logic [src_pkg::ACCEL_W-1:0] accel_limit;
  logic [CW-1:0]               max_rate;
  logic [CW-1:0]               min_rate;
  logic [src_pkg::TOL_W-1:0]   angle_tolerance;

  logic                 in_start;
  logic signed [HW-1:0] in_cur;
  logic                 in_cancel;
  logic                 in_coll;

  src_pkg::phase_t      phase;
  logic signed [HW-1:0] last_heading;
  logic signed [UW-1:0] unwrapped;
  logic signed [UW-1:0] origin;

  logic [src_pkg::DIST_W-1:0] dist_mag;
  logic [AW-1:0]              rem_mag;
  logic signed [OW-1:0]       res_rate;
  src_pkg::phase_t            res_phase;
  src_pkg::status_t           res_status;

  src_pkg::phase_t      eff_phase;
  logic signed [HW-1:0] eff_last;
  logic signed [UW-1:0] eff_unw;
  logic signed [UW-1:0] cur_ext;
  logic                 run;
  logic                 proceed;
  logic signed [DW-1:0] prev_x;
  logic signed [DW-1:0] cur_x;
  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] abs_x;
  logic signed [DW-1:0] delta;
  logic signed [UW-1:0] new_unw;

  logic signed [src_pkg::DIST_W-1:0] dist_s;
  logic [src_pkg::SWING_W-1:0] a_val;
  logic [AW-1:0]               amp;
  logic signed [RW-1:0]        rem;
  logic signed [RW-1:0]        tol_x;
  logic                        rem_low;
  logic                        rem_pos;
  logic                        coll_stop;
  src_pkg::phase_t             next_phase;

  logic [src_pkg::ACCEL_W+AW-1:0] prod;
  logic [src_pkg::RAD_W-1:0]      radicand;
  logic [QW-1:0]                  root;
  logic                           sqrt_last;
  logic [QW-1:0]                  lo;
  logic [QW-1:0]                  hi;
  logic [OW-1:0]                  mag_x;
  logic signed [OW-1:0]           rate_val;
  logic [OW-1:0]                  res_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      swing_angle_deg <= src_pkg::SWING_RST;
      accel_limit <= src_pkg::ACCEL_RST;
      max_rate <= src_pkg::MAX_RATE_RST;
      min_rate <= src_pkg::MIN_RATE_RST;
      angle_tolerance <= src_pkg::TOL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        src_pkg::CFG_SWING:    swing_angle_deg <= cfg_data[src_pkg::DEG_W-1:0];
        src_pkg::CFG_ACCEL:    accel_limit <= cfg_data[src_pkg::ACCEL_W-1:0];
        src_pkg::CFG_MAX_RATE: max_rate <= cfg_data[CW-1:0];
        src_pkg::CFG_MIN_RATE: min_rate <= cfg_data[CW-1:0];
        src_pkg::CFG_TOL:      angle_tolerance <= cfg_data[src_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_start <= start_run;
      in_cur <= heading;
      in_cancel <= cancel_req;
      in_coll <= collision_ahead;
    end
  end

  // A start takes effect before the rest of the word is handled.
  always_comb begin
    cur_ext = {{(UW-HW){in_cur[HW-1]}}, in_cur};
    eff_phase = in_start ? src_pkg::PH_POS : phase;
    eff_last = in_start ? in_cur : last_heading;
    eff_unw = in_start ? cur_ext : unwrapped;
    run = (eff_phase != src_pkg::PH_IDLE);
    proceed = run && !in_cancel;
    prev_x = {{(DW-HW){eff_last[HW-1]}}, eff_last};
    cur_x = {{(DW-HW){in_cur[HW-1]}}, in_cur};
    diff_x = cur_x - prev_x;
    abs_x = diff_x[DW-1] ? -diff_x : diff_x;
    if (eff_phase == src_pkg::PH_NEG) begin
      if (prev_x < -src_pkg::HALF_PI_Q && cur_x > src_pkg::HALF_PI_Q) begin
        delta = -((src_pkg::PI_Q + prev_x) + (src_pkg::PI_Q - cur_x));
      end else begin
        delta = -abs_x;
      end
    end else begin
      if (prev_x > src_pkg::HALF_PI_Q && cur_x < -src_pkg::HALF_PI_Q) begin
        delta = (src_pkg::PI_Q - prev_x) + (cur_x + src_pkg::PI_Q);
      end else begin
        delta = abs_x;
      end
    end
    new_unw = eff_unw + {{(UW-DW){delta[DW-1]}}, delta};
  end

  always_comb begin
    dist_s = {unwrapped[UW-1], unwrapped} - {origin[UW-1], origin};
    a_val = src_pkg::SWING_TBL[swing_angle_deg];
    amp = (phase == src_pkg::PH_NEG) ? {a_val, 1'b0} : {1'b0, a_val};
    rem = $signed({{(RW-AW){1'b0}}, amp}) - $signed({1'b0, dist_mag});
    tol_x = $signed({{(RW-src_pkg::TOL_W){1'b0}}, angle_tolerance});
    rem_low = (rem < tol_x);
    rem_pos = !rem[RW-1] && (rem != '0);
    coll_stop = in_coll && rem_pos;
    case (phase)
      src_pkg::PH_POS: next_phase = src_pkg::PH_NEG;
      src_pkg::PH_NEG: next_phase = src_pkg::PH_RET;
      default:         next_phase = src_pkg::PH_IDLE;
    endcase
  end

  assign prod = accel_limit * rem_mag;
  assign radicand = {{(src_pkg::RAD_W-src_pkg::PROD_W){1'b0}}, prod, 1'b0};

  src_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.mul),
    .radicand (radicand),
    .step     (cmd.step),
    .root     (root),
    .last     (sqrt_last)
  );

  // Raise to the floor first, then cap, so a floor above the cap yields the cap.
  always_comb begin
    lo = (root < {{(QW-CW){1'b0}}, min_rate}) ? {{(QW-CW){1'b0}}, min_rate} : root;
    hi = (lo > {{(QW-CW){1'b0}}, max_rate}) ? {{(QW-CW){1'b0}}, max_rate} : lo;
    mag_x = {{(OW-CW){1'b0}}, hi[CW-1:0]};
    rate_val = (phase == src_pkg::PH_NEG) ? -$signed(mag_x) : $signed(mag_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= src_pkg::PH_IDLE;
      last_heading <= '0;
      unwrapped <= '0;
      origin <= '0;
    end else begin
      if (cmd.upd) begin
        phase <= proceed ? eff_phase : src_pkg::PH_IDLE;
        if (in_start || proceed) begin
          last_heading <= in_cur;
        end
        if (proceed) begin
          unwrapped <= new_unw;
        end else if (in_start) begin
          unwrapped <= cur_ext;
        end
        if (in_start) begin
          origin <= cur_ext;
        end
      end
      if (cmd.cmp) begin
        if (coll_stop) begin
          phase <= src_pkg::PH_IDLE;
        end else if (rem_low) begin
          origin <= unwrapped;
          phase <= next_phase;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.meas) begin
      dist_mag <= dist_s[src_pkg::DIST_W-1] ? -dist_s : dist_s;
    end
    if (cmd.cmp) begin
      rem_mag <= rem[AW-1:0];
    end
    if (cmd.upd) begin
      res_rate <= '0;
      res_phase <= src_pkg::PH_IDLE;
      res_status <= (run && in_cancel) ? src_pkg::ST_ABORT : src_pkg::ST_NONE;
    end
    if (cmd.cmp) begin
      res_rate <= '0;
      if (coll_stop) begin
        res_phase <= src_pkg::PH_IDLE;
        res_status <= src_pkg::ST_ABORT;
      end else begin
        res_phase <= next_phase;
        res_status <= (phase == src_pkg::PH_RET) ? src_pkg::ST_DONE : src_pkg::ST_NONE;
      end
    end
    if (cmd.clamp) begin
      res_rate <= rate_val;
      res_phase <= phase;
      res_status <= src_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      turn_rate <= res_rate;
      phase_now <= res_phase;
      run_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.upd_stop = !proceed;
    stat.cmp_stop = coll_stop || rem_low;
    stat.sqrt_last = sqrt_last;
    stat.out_free = !out_valid || !out_stall;
  end

  assign res_mag = res_rate[OW-1] ? -res_rate : res_rate;

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result word not presented after emit");

  a_idle_still: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase_now == src_pkg::PH_IDLE) |-> (turn_rate == '0))
    else $error("non-zero turn rate reported with the phase idle");

  a_rate_capped: assert property (@(posedge clk) disable iff (rst)
    cmd.clamp |=> (res_mag <= {{(OW-CW){1'b0}}, $past(max_rate)}))
    else $error("clamped rate exceeds the maximum rate");

endmodule

`default_nettype wire

// ===== rtl/core/swing_rotation_controller.sv =====
`default_nettype none

// Swing rotation controller: one heading word in gives one rate word out. A word that
// needs a fresh rate passes the remaining-angle multiply and then the 17-step
// bit-serial square root before its result is presented; one that leaves the run idle
// or cancels it goes to the output right after the heading update, and one that ends
// a phase or stops on a collision, right after the remaining-angle compare. Only one
// word is in work at a time, and the next is accepted as soon as the previous result
// sits in the output register, even if it is not yet taken. Configuration is written
// through cfg_write, cfg_index and cfg_data while no word is in work, a rule on the
// user that the block does not enforce; indices beyond the last register are ignored.
module swing_rotation_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [src_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [src_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  start_run,
  input  logic signed [src_pkg::HEADING_W-1:0]  heading,
  input  logic                                  cancel_req,
  input  logic                                  collision_ahead,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [src_pkg::RATE_W-1:0]     turn_rate,
  output logic [1:0]                            phase_now,
  output logic [1:0]                            run_status
);

  src_pkg::cmd_t  cmd;
  src_pkg::stat_t stat;

  src_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  src_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start_run       (start_run),
    .heading         (heading),
    .cancel_req      (cancel_req),
    .collision_ahead (collision_ahead),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .turn_rate       (turn_rate),
    .phase_now       (phase_now),
    .run_status      (run_status)
  );

endmodule

`default_nettype wire
